// ===== rtl/epmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder position move controller package
// Shared types and constants: controller modes, register indexes, reset
// values of the configuration registers, and the input and result words.
// ----------------------------------------------------------------------------
package epmc_pkg;

  // Controller mode, encoded as shown on the mode_now output.
  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_JOG_FWD  = 2'd1,
    MODE_JOG_BACK = 2'd2,
    MODE_AUTO     = 2'd3
  } mode_t;

  // Configuration port geometry.
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 14;
  localparam int StepWidth     = 8;
  localparam int PresetWidth   = 14;
  localparam int ResultPosWidth = 32;

  // Register indexes.
  localparam logic [CfgIndexWidth-1:0] CFG_STEP_SIZE     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_CANCEL_PRESET = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_CANCEL_TARGET = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_ENTER_PRESET  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_ENTER_TARGET  = 3'd4;

  // Register reset values.
  localparam logic [StepWidth-1:0]   STEP_SIZE_RESET     = 8'd1;
  localparam logic [PresetWidth-1:0] CANCEL_PRESET_RESET = 14'd0;
  localparam logic [PresetWidth-1:0] CANCEL_TARGET_RESET = 14'd5000;
  localparam logic [PresetWidth-1:0] ENTER_PRESET_RESET  = 14'd9000;
  localparam logic [PresetWidth-1:0] ENTER_TARGET_RESET  = 14'd4000;

  // Configuration register set.
  typedef struct packed {
    logic [StepWidth-1:0]   step_size;
    logic [PresetWidth-1:0] cancel_preset;
    logic [PresetWidth-1:0] cancel_target;
    logic [PresetWidth-1:0] enter_preset;
    logic [PresetWidth-1:0] enter_target;
  } cfg_t;

  // One input word: encoder lines and buttons of one sample tick.
  typedef struct packed {
    logic enc_a;
    logic enc_b;
    logic jog_fwd_pressed;
    logic jog_back_pressed;
    logic guard_ok;
    logic cancel_pressed;
    logic enter_pressed;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic                             drive_forward;
    logic                             drive_backward;
    logic signed [ResultPosWidth-1:0] position_now;
    logic                             last_dir_forward;
    mode_t                            mode_now;
  } res_word_t;

endpackage

// ===== rtl/epmc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder position move controller core
// Holds the controller state. For each accepted word it counts the encoder
// step, runs the mode state machine and forms the result word in one pass.
// ----------------------------------------------------------------------------
module epmc_ctrl #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  epmc_pkg::in_word_t in_word,
  input  epmc_pkg::cfg_t     cfg,
  output epmc_pkg::res_word_t res_word
);

  // State registers.
  logic [POSITION_WIDTH-1:0] position;
  logic [POSITION_WIDTH-1:0] target_position;
  logic                      count_enable;
  logic                      prev_a;
  epmc_pkg::mode_t           mode;
  logic                      auto_toward_higher;
  logic                      dir_forward_flag;

  logic [POSITION_WIDTH-1:0] position_next;
  logic [POSITION_WIDTH-1:0] target_position_next;
  logic                      count_enable_next;
  epmc_pkg::mode_t           mode_next;
  logic                      auto_toward_higher_next;
  logic                      dir_forward_flag_next;

  logic                      count_edge;
  logic [POSITION_WIDTH-1:0] step_ext;
  logic [POSITION_WIDTH-1:0] pos_stepped;
  logic                      fwd_jog;
  logic                      back_jog;
  logic                      auto_req;
  logic [POSITION_WIDTH-1:0] auto_preset;
  logic [POSITION_WIDTH-1:0] auto_target;
  logic                      preset_below;
  logic                      preset_above;
  logic                      reached_high;
  logic                      reached_low;
  logic                      hold_jog;

  // Encoder step: a falling edge of A counts while counting is enabled.
  assign count_edge = count_enable && prev_a && !in_word.enc_a;
  assign step_ext   = POSITION_WIDTH'(cfg.step_size);

  always_comb begin
    pos_stepped           = position;
    dir_forward_flag_next = dir_forward_flag;
    if (count_edge) begin
      dir_forward_flag_next = in_word.enc_b;
      if (in_word.enc_b) begin
        pos_stepped = position - step_ext;
      end else begin
        pos_stepped = position + step_ext;
      end
    end
  end

  // Button decode and auto move setup values.
  assign fwd_jog  = in_word.jog_fwd_pressed && in_word.guard_ok;
  assign back_jog = in_word.jog_back_pressed && in_word.guard_ok;
  assign auto_req = in_word.cancel_pressed || in_word.enter_pressed;
  assign auto_preset = in_word.cancel_pressed ? POSITION_WIDTH'(cfg.cancel_preset)
                                              : POSITION_WIDTH'(cfg.enter_preset);
  assign auto_target = in_word.cancel_pressed ? POSITION_WIDTH'(cfg.cancel_target)
                                              : POSITION_WIDTH'(cfg.enter_target);
  assign preset_below = $signed(auto_preset) < $signed(auto_target);
  assign preset_above = $signed(auto_target) < $signed(auto_preset);

  // Auto move end tests against the stepped position.
  assign reached_high = !($signed(pos_stepped) < $signed(target_position));
  assign reached_low  = !($signed(target_position) < $signed(pos_stepped));

  // A jog continues while its own button and the guard are held.
  assign hold_jog = ((mode == epmc_pkg::MODE_JOG_FWD) && fwd_jog) ||
                    ((mode == epmc_pkg::MODE_JOG_BACK) && back_jog);

  // Next state of the mode machine.
  always_comb begin
    position_next           = pos_stepped;
    target_position_next    = target_position;
    count_enable_next       = count_enable;
    mode_next               = mode;
    auto_toward_higher_next = auto_toward_higher;
    if (mode == epmc_pkg::MODE_AUTO) begin
      if (auto_toward_higher ? reached_high : reached_low) begin
        mode_next = epmc_pkg::MODE_IDLE;
      end
    end else if (hold_jog) begin
      count_enable_next = 1'b0;
    end else begin
      // Idle evaluation; a released jog skips its own and higher jogs.
      mode_next = epmc_pkg::MODE_IDLE;
      priority if ((mode == epmc_pkg::MODE_IDLE) && fwd_jog) begin
        mode_next         = epmc_pkg::MODE_JOG_FWD;
        count_enable_next = 1'b0;
      end else if ((mode != epmc_pkg::MODE_JOG_BACK) && back_jog) begin
        mode_next         = epmc_pkg::MODE_JOG_BACK;
        count_enable_next = 1'b0;
      end else if (auto_req) begin
        position_next        = auto_preset;
        target_position_next = auto_target;
        count_enable_next    = 1'b1;
        if (preset_below) begin
          auto_toward_higher_next = 1'b1;
          mode_next               = epmc_pkg::MODE_AUTO;
        end else if (preset_above) begin
          auto_toward_higher_next = 1'b0;
          mode_next               = epmc_pkg::MODE_AUTO;
        end
      end else begin
        // No button acts, so the controller stays idle.
      end
    end
  end

  // Result word from the state at the end of the tick.
  always_comb begin
    res_word.drive_forward    = 1'b0;
    res_word.drive_backward   = 1'b0;
    res_word.position_now     = epmc_pkg::ResultPosWidth'($signed(position_next));
    res_word.last_dir_forward = dir_forward_flag_next;
    res_word.mode_now         = mode_next;
    unique case (mode_next)
      epmc_pkg::MODE_JOG_FWD:  res_word.drive_forward = 1'b1;
      epmc_pkg::MODE_JOG_BACK: res_word.drive_backward = 1'b1;
      epmc_pkg::MODE_AUTO: begin
        res_word.drive_backward = auto_toward_higher_next;
        res_word.drive_forward  = !auto_toward_higher_next;
      end
      default: begin
      end
    endcase
  end

  // State update on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      position           <= '0;
      target_position    <= '0;
      count_enable       <= 1'b0;
      prev_a             <= 1'b0;
      mode               <= epmc_pkg::MODE_IDLE;
      auto_toward_higher <= 1'b0;
      dir_forward_flag   <= 1'b0;
    end else if (step_en) begin
      position           <= position_next;
      target_position    <= target_position_next;
      count_enable       <= count_enable_next;
      prev_a             <= in_word.enc_a;
      mode               <= mode_next;
      auto_toward_higher <= auto_toward_higher_next;
      dir_forward_flag   <= dir_forward_flag_next;
    end
  end

endmodule

// ===== rtl/encoder_position_move_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder position move controller
// Counts quadrature encoder steps and runs jog and automatic moves. One
// input word per sample tick gives one result word.
// The result word is registered in the output register, or in the skid
// register under output stall. Throughput: one word per cycle while
// in_stall is low, set by the single-pass state update; the two-word
// output buffer takes one more word under output stall. Reset clears the
// controller state, restores the register defaults and empties the buffer.
// ----------------------------------------------------------------------------
module encoder_position_move_controller_top #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [epmc_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [epmc_pkg::CfgDataWidth-1:0]    cfg_data,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 enc_a,
  input  logic                                 enc_b,
  input  logic                                 jog_fwd_pressed,
  input  logic                                 jog_back_pressed,
  input  logic                                 guard_ok,
  input  logic                                 cancel_pressed,
  input  logic                                 enter_pressed,
  // Output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 drive_forward,
  output logic                                 drive_backward,
  output logic signed [epmc_pkg::ResultPosWidth-1:0] position_now,
  output logic                                 last_dir_forward,
  output logic [1:0]                           mode_now
);

  epmc_pkg::cfg_t      cfg;
  epmc_pkg::in_word_t  in_word;
  epmc_pkg::res_word_t res_new;
  epmc_pkg::res_word_t out_res;
  epmc_pkg::res_word_t skid_res;
  logic                skid_valid;
  logic                in_accept;
  logic                out_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size     <= epmc_pkg::STEP_SIZE_RESET;
      cfg.cancel_preset <= epmc_pkg::CANCEL_PRESET_RESET;
      cfg.cancel_target <= epmc_pkg::CANCEL_TARGET_RESET;
      cfg.enter_preset  <= epmc_pkg::ENTER_PRESET_RESET;
      cfg.enter_target  <= epmc_pkg::ENTER_TARGET_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        epmc_pkg::CFG_STEP_SIZE:     cfg.step_size <= cfg_data[epmc_pkg::StepWidth-1:0];
        epmc_pkg::CFG_CANCEL_PRESET: cfg.cancel_preset <= cfg_data;
        epmc_pkg::CFG_CANCEL_TARGET: cfg.cancel_target <= cfg_data;
        epmc_pkg::CFG_ENTER_PRESET:  cfg.enter_preset <= cfg_data;
        epmc_pkg::CFG_ENTER_TARGET:  cfg.enter_target <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input word assembly and handshake.
  assign in_word = '{enc_a:            enc_a,
                     enc_b:            enc_b,
                     jog_fwd_pressed:  jog_fwd_pressed,
                     jog_back_pressed: jog_back_pressed,
                     guard_ok:         guard_ok,
                     cancel_pressed:   cancel_pressed,
                     enter_pressed:    enter_pressed};
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  epmc_ctrl #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .step_en  (in_accept),
    .in_word  (in_word),
    .cfg      (cfg),
    .res_word (res_new)
  );

  // Output register and skid stage: valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      if (!out_valid || !out_stall) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // Output register and skid stage: payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!out_valid || !out_stall) begin
        out_res <= res_new;
      end else begin
        skid_res <= res_new;
      end
    end else if (out_take && skid_valid) begin
      out_res <= skid_res;
    end
  end

  // Result word fields.
  assign drive_forward    = out_res.drive_forward;
  assign drive_backward   = out_res.drive_backward;
  assign position_now     = out_res.position_now;
  assign last_dir_forward = out_res.last_dir_forward;
  assign mode_now         = out_res.mode_now;

endmodule
